/* design/tournament_branch_predictor_top_defines.svh */
// ---------------------------------------------------------------------------
// assertion macros for the tournament branch predictor
// ---------------------------------------------------------------------------
`ifndef TOURNAMENT_BRANCH_PREDICTOR_TOP_DEFINES_SVH
`define TOURNAMENT_BRANCH_PREDICTOR_TOP_DEFINES_SVH

// checked only out of reset
`define TBP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked at every edge, reset included
`define TBP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

/* design/tbp_pkg.sv */
// ---------------------------------------------------------------------------
// tbp_pkg
// sizes, types and counter helpers of the tournament branch predictor
// ---------------------------------------------------------------------------
`default_nettype none

package tbp_pkg;

  localparam int unsigned ADDR_INDEX_BITS = 10;
  localparam int unsigned HISTORY_BITS    = 10;
  localparam int unsigned ADDR_DEPTH      = 1 << ADDR_INDEX_BITS;
  localparam int unsigned HIST_DEPTH      = 1 << HISTORY_BITS;
  localparam int unsigned CLR_BITS        =
    (ADDR_INDEX_BITS > HISTORY_BITS) ? ADDR_INDEX_BITS : HISTORY_BITS;

  localparam int unsigned PC_BITS = 32;

  typedef logic [1:0]                 ctr_t;
  typedef logic [ADDR_INDEX_BITS-1:0] addr_idx_t;
  typedef logic [HISTORY_BITS-1:0]    hist_t;

  typedef enum logic {
    REQ_PREDICT = 1'b0,
    REQ_UPDATE  = 1'b1
  } req_e;

  localparam ctr_t CTR_MIN = 2'd0;
  localparam ctr_t CTR_MAX = 2'd3;

  function automatic ctr_t sat_up(input ctr_t c);
    return (c == CTR_MAX) ? CTR_MAX : ctr_t'(c + 2'd1);
  endfunction

  function automatic ctr_t sat_down(input ctr_t c);
    return (c == CTR_MIN) ? CTR_MIN : ctr_t'(c - 2'd1);
  endfunction

endpackage

`default_nettype wire

/* design/tournament_branch_predictor_top.sv */
// Predictions pass stage 1 and then the output register. Throughput: one word per cycle,
// predict or update, while in_stall_o is low; counter tables are read at accept and
// written back the next cycle, with a one-entry bypass for back-to-back hits. Reset:
// history and control clear at once, then a clearing pass over all 2**CLR_BITS addresses
// (1024 here) zeroes the three tables while in_stall_o is held high.
// ---------------------------------------------------------------------------
// tournament_branch_predictor_top
// global/local/chooser 2-bit counter predictor with global history
// ---------------------------------------------------------------------------
`default_nettype none

`include "tournament_branch_predictor_top_defines.svh"

module tournament_branch_predictor_top (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output      logic                     in_stall_o,
  input  wire logic                     req_type_i,
  input  wire logic [tbp_pkg::PC_BITS-1:0] pc_address_i,
  input  wire logic                     taken_i,
  output      logic                     out_valid_o,
  input  wire logic                     out_stall_i,
  output      logic                     predict_taken_o
);
  import tbp_pkg::*;

  // table storage
  ctr_t glb_mem [HIST_DEPTH];
  ctr_t loc_mem [ADDR_DEPTH];
  ctr_t cho_mem [ADDR_DEPTH];

  // clearing pass
  logic                clr_busy_q, clr_busy_d;
  logic [CLR_BITS-1:0] clr_cnt_q, clr_cnt_d;

  // history
  hist_t hist_q, hist_d;

  // stage 1
  logic      s1_valid_q, s1_valid_d;
  logic      s1_upd_q;
  logic      s1_tkn_q;
  addr_idx_t s1_a_q;
  hist_t     s1_h_q;
  ctr_t      glb_rd_q, loc_rd_q, cho_rd_q;

  // bypass of the write made at the edge of the last accept
  logic      fwd_vld_q;
  hist_t     fwd_h_q;
  addr_idx_t fwd_a_q;
  ctr_t      fwd_g_q, fwd_l_q, fwd_c_q;

  // output register
  logic out_valid_q, out_valid_d;
  logic pred_q;

  logic      in_accept;
  logic      s1_adv;
  logic      s1_wr;
  addr_idx_t in_a;
  ctr_t      g_cur, l_cur, c_cur;
  ctr_t      g_new, l_new, c_new;
  logic      gp, lp, pred;

  logic      glb_we, loc_we;
  hist_t     glb_wa;
  addr_idx_t loc_wa;
  ctr_t      glb_wd, loc_wd, cho_wd;

  assign in_a = pc_address_i[ADDR_INDEX_BITS-1:0];

  // a predict waits only when the output register is full and stalled
  assign s1_adv     = s1_valid_q & ~(~s1_upd_q & out_valid_q & out_stall_i);
  assign in_stall_o = clr_busy_q | (s1_valid_q & ~s1_adv);
  assign in_accept  = in_valid_i & ~in_stall_o;
  assign s1_wr      = s1_valid_q & s1_upd_q;

  assign s1_valid_d  = in_accept | (s1_valid_q & ~s1_adv);
  assign out_valid_d = (s1_adv & ~s1_upd_q) | (out_valid_q & out_stall_i);

  assign hist_d = (in_accept && req_type_i == REQ_UPDATE) ?
                  {hist_q[HISTORY_BITS-2:0], taken_i} : hist_q;

  assign clr_busy_d = clr_busy_q & ~(&clr_cnt_q);
  assign clr_cnt_d  = clr_busy_q ? clr_cnt_q + 1'b1 : clr_cnt_q;

  always_comb begin
    g_cur = (fwd_vld_q && fwd_h_q == s1_h_q) ? fwd_g_q : glb_rd_q;
    l_cur = (fwd_vld_q && fwd_a_q == s1_a_q) ? fwd_l_q : loc_rd_q;
    c_cur = (fwd_vld_q && fwd_a_q == s1_a_q) ? fwd_c_q : cho_rd_q;
    gp    = g_cur[1];
    lp    = l_cur[1];
    pred  = c_cur[1] ? lp : gp;

    // chooser moves toward the predictor that alone was right
    c_new = c_cur;
    if (gp == s1_tkn_q && lp != s1_tkn_q) begin
      c_new = sat_down(c_cur);
    end else if (gp != s1_tkn_q && lp == s1_tkn_q) begin
      c_new = sat_up(c_cur);
    end
    g_new = s1_tkn_q ? sat_up(g_cur) : sat_down(g_cur);
    l_new = s1_tkn_q ? sat_up(l_cur) : sat_down(l_cur);
  end

  assign glb_we = clr_busy_q | s1_wr;
  assign loc_we = clr_busy_q | s1_wr;
  assign glb_wa = clr_busy_q ? clr_cnt_q[HISTORY_BITS-1:0] : s1_h_q;
  assign loc_wa = clr_busy_q ? clr_cnt_q[ADDR_INDEX_BITS-1:0] : s1_a_q;
  assign glb_wd = clr_busy_q ? CTR_MIN : g_new;
  assign loc_wd = clr_busy_q ? CTR_MIN : l_new;
  assign cho_wd = clr_busy_q ? CTR_MIN : c_new;

  always_ff @(posedge clk_i) begin
    if (glb_we) begin
      glb_mem[glb_wa] <= glb_wd;
    end
    if (in_accept) begin
      glb_rd_q <= glb_mem[hist_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (loc_we) begin
      loc_mem[loc_wa] <= loc_wd;
    end
    if (in_accept) begin
      loc_rd_q <= loc_mem[in_a];
    end
  end

  always_ff @(posedge clk_i) begin
    if (loc_we) begin
      cho_mem[loc_wa] <= cho_wd;
    end
    if (in_accept) begin
      cho_rd_q <= cho_mem[in_a];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q  <= 1'b1;
      clr_cnt_q   <= '0;
      hist_q      <= '0;
      s1_valid_q  <= 1'b0;
      fwd_vld_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      clr_busy_q  <= clr_busy_d;
      clr_cnt_q   <= clr_cnt_d;
      hist_q      <= hist_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (in_accept) begin
        fwd_vld_q <= s1_wr;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_upd_q <= (req_type_i == REQ_UPDATE);
      s1_tkn_q <= taken_i;
      s1_a_q   <= in_a;
      s1_h_q   <= hist_q;
      fwd_h_q  <= s1_h_q;
      fwd_a_q  <= s1_a_q;
      fwd_g_q  <= g_new;
      fwd_l_q  <= l_new;
      fwd_c_q  <= c_new;
    end
    if (s1_adv && !s1_upd_q) begin
      pred_q <= pred;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign predict_taken_o = pred_q;

  `TBP_ASSERT_ALWAYS(a_clr_holds_input, clr_busy_q |-> (in_stall_o && !s1_valid_q),
                     "word in flight during clearing pass")
  `TBP_ASSERT(a_upd_never_waits, (s1_valid_q && s1_upd_q) |-> s1_adv,
              "update word held in stage 1")
  `TBP_ASSERT(a_hist_shift, (in_accept && req_type_i == REQ_UPDATE) |=> hist_q[0] == $past(taken_i),
              "history did not take the outcome")
  `TBP_ASSERT(a_wr_port_excl, !(clr_busy_q && s1_wr),
              "clearing and update write collide")

endmodule

`default_nettype wire

/* tb/tournament_branch_predictor_top_tb.sv */
// ---------------------------------------------------------------------------
// tournament_branch_predictor_top_tb
// Self-checking bench for the tournament branch predictor. A clocked driver
// feeds predict and update words from a queue of pending words. A
// word-level model of the global, local and chooser tables tracks every
// accepted word and queues the expected prediction. A clocked monitor
// checks each returned prediction against that queue. Both sides idle at
// random, with calm stretches between.
// ---------------------------------------------------------------------------
`default_nettype none

module tournament_branch_predictor_top_tb;

  import tbp_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned SETTLE_CYCLES  = 12;
  localparam int unsigned RANDOM_WORDS   = 800;
  localparam int unsigned POOL_SIZE      = 8;
  localparam int unsigned PC_HI_BITS     = PC_BITS - ADDR_INDEX_BITS;

  typedef struct packed {
    req_e               kind;
    logic [PC_BITS-1:0] pc;
    logic               taken;
  } branch_word_t;

  logic               clk_i        = 1'b0;
  logic               rst_ni       = 1'b0;
  logic               in_valid_i   = 1'b0;
  logic               req_type_i   = 1'b0;
  logic [PC_BITS-1:0] pc_address_i = '0;
  logic               taken_i      = 1'b0;
  logic               out_stall_i  = 1'b0;
  logic               in_stall_o;
  logic               out_valid_o;
  logic               predict_taken_o;

  tournament_branch_predictor_top u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .req_type_i     (req_type_i),
    .pc_address_i   (pc_address_i),
    .taken_i        (taken_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .predict_taken_o(predict_taken_o)
  );

  always #5 clk_i = ~clk_i;

  // shadow copy of the predictor state
  ctr_t  glob_ctr [HIST_DEPTH];
  ctr_t  loc_ctr  [ADDR_DEPTH];
  ctr_t  chs_ctr  [ADDR_DEPTH];
  hist_t ghist;

  branch_word_t pending_q[$];
  logic         want_taken_q[$];

  int unsigned err_cnt      = 0;
  int unsigned predicts_in  = 0;
  int unsigned updates_in   = 0;
  int unsigned results_seen = 0;
  int unsigned idle_cycles  = 0;
  int unsigned in_gap       = 0;
  int unsigned out_hold     = 0;
  bit          in_calm      = 1'b0;
  bit          out_calm     = 1'b0;

  function automatic int unsigned draw_wait(input bit calm);
    return calm ? 0 : $urandom_range(0, 7);
  endfunction

  function automatic ctr_t ctr_toward(input ctr_t c, input logic up);
    if (up) begin
      return (c == CTR_MAX) ? c : ctr_t'(c + 2'd1);
    end
    return (c == CTR_MIN) ? c : ctr_t'(c - 2'd1);
  endfunction

  // predict: queue the chosen counter's direction; update: train all three tables
  task automatic track_branch(input branch_word_t w);
    addr_idx_t a;
    logic      g_dir;
    logic      l_dir;
    a     = w.pc[ADDR_INDEX_BITS-1:0];
    g_dir = glob_ctr[ghist][1];
    l_dir = loc_ctr[a][1];
    if (w.kind == REQ_PREDICT) begin
      want_taken_q.push_back(chs_ctr[a][1] ? l_dir : g_dir);
      predicts_in++;
    end else begin
      // chooser only moves when exactly one side was right
      if (g_dir == w.taken && l_dir != w.taken) begin
        chs_ctr[a] = ctr_toward(chs_ctr[a], 1'b0);
      end else if (g_dir != w.taken && l_dir == w.taken) begin
        chs_ctr[a] = ctr_toward(chs_ctr[a], 1'b1);
      end
      glob_ctr[ghist] = ctr_toward(glob_ctr[ghist], w.taken);
      loc_ctr[a]      = ctr_toward(loc_ctr[a], w.taken);
      ghist           = hist_t'({ghist, w.taken});
      updates_in++;
    end
  endtask

  function automatic branch_word_t mk_word(input req_e k, input logic [PC_BITS-1:0] pc,
                                           input logic tk);
    branch_word_t w;
    w.kind  = k;
    w.pc    = pc;
    w.taken = tk;
    return w;
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin : drv_proc
    logic         take;
    branch_word_t w;
    if (!rst_ni) begin
      in_valid_i   <= 1'b0;
      req_type_i   <= 1'b0;
      pc_address_i <= '0;
      taken_i      <= 1'b0;
    end else begin
      take = in_valid_i && !in_stall_o;
      if (take) begin
        track_branch(mk_word(req_e'(req_type_i), pc_address_i, taken_i));
        if ((predicts_in + updates_in) % 64 == 0) begin
          in_calm = ($urandom_range(0, 3) == 0);
        end
      end
      if (!in_valid_i || take) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid_i <= 1'b0;
        end else if (pending_q.size() > 0) begin
          w = pending_q.pop_front();
          req_type_i   <= w.kind;
          pc_address_i <= w.pc;
          taken_i      <= w.taken;
          in_valid_i   <= 1'b1;
          in_gap       = draw_wait(in_calm);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin : mon_proc
    logic hit;
    logic want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      hit = out_valid_o && !out_stall_i;
      if (hit) begin
        results_seen++;
        if (want_taken_q.size() == 0) begin
          $display("%0t: unexpected prediction word, expected none actual %b",
                   $time, predict_taken_o);
          err_cnt++;
        end else begin
          want = want_taken_q.pop_front();
          if (predict_taken_o !== want) begin
            $display("%0t: predict_taken mismatch, expected %b actual %b",
                     $time, want, predict_taken_o);
            err_cnt++;
          end
        end
        if (results_seen % 64 == 0) begin
          out_calm = ($urandom_range(0, 3) == 0);
        end
        out_hold = draw_wait(out_calm);
      end
      if (out_hold > 0) begin
        out_hold--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : main_proc
    logic [ADDR_INDEX_BITS-1:0] pool     [POOL_SIZE];
    int unsigned                bias     [POOL_SIZE];
    int unsigned                k;
    logic [PC_BITS-1:0]         pc;
    req_e                       kind;
    logic                       tk;

    foreach (glob_ctr[i]) glob_ctr[i] = CTR_MIN;
    foreach (loc_ctr[i])  loc_ctr[i]  = CTR_MIN;
    foreach (chs_ctr[i])  chs_ctr[i]  = CTR_MIN;
    ghist = '0;

    // directed words: address extremes, ignored taken on predict,
    // saturation both ways, high-bit aliasing
    pending_q.push_back(mk_word(REQ_PREDICT, 32'h0000_0000, 1'b1));
    pending_q.push_back(mk_word(REQ_PREDICT, 32'hFFFF_FFFF, 1'b0));
    pending_q.push_back(mk_word(REQ_UPDATE,  32'h0000_0000, 1'b0));
    repeat (5) pending_q.push_back(mk_word(REQ_UPDATE, 32'h0000_0010, 1'b1));
    pending_q.push_back(mk_word(REQ_PREDICT, 32'h0000_0010, 1'b0));
    pending_q.push_back(mk_word(REQ_PREDICT, 32'hFFFF_FC10, 1'b1));
    repeat (5) pending_q.push_back(mk_word(REQ_UPDATE, 32'hABCD_E010, 1'b0));
    pending_q.push_back(mk_word(REQ_PREDICT, 32'h0000_0010, 1'b1));
    pending_q.push_back(mk_word(REQ_UPDATE,  32'hFFFF_FFFF, 1'b1));
    pending_q.push_back(mk_word(REQ_UPDATE,  32'h0000_03FF, 1'b1));
    pending_q.push_back(mk_word(REQ_UPDATE,  32'h8000_03FF, 1'b0));
    pending_q.push_back(mk_word(REQ_PREDICT, 32'h0000_03FF, 1'b0));
    pending_q.push_back(mk_word(REQ_PREDICT, 32'hFFFF_FFFF, 1'b1));
    pending_q.push_back(mk_word(REQ_PREDICT, 32'h5555_5555, 1'b0));
    pending_q.push_back(mk_word(REQ_PREDICT, 32'hAAAA_AAAA, 1'b1));

    // random words: mostly a small set of hot branches with biased
    // outcomes so the tables train, plus fully random noise
    foreach (pool[i]) begin
      pool[i] = addr_idx_t'($urandom());
      bias[i] = $urandom_range(0, 10);
    end
    pool[0] = '0;
    pool[1] = '1;
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      kind = ($urandom_range(0, 99) < 55) ? REQ_UPDATE : REQ_PREDICT;
      if ($urandom_range(0, 4) != 0) begin
        k  = $urandom_range(0, POOL_SIZE - 1);
        pc = {PC_HI_BITS'($urandom()), pool[k]};
        tk = ($urandom_range(0, 9) < bias[k]);
      end else begin
        pc = $urandom();
        tk = 1'($urandom_range(0, 1));
      end
      pending_q.push_back(mk_word(kind, pc, tk));
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (!(pending_q.size() == 0 && !in_valid_i && want_taken_q.size() == 0)
           && idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired, %0d predictions outstanding",
               $time, want_taken_q.size());
      $display("== FAIL ==");
    end else begin
      $display("covered %0d predict and %0d update words, %0d predictions checked",
               predicts_in, updates_in, results_seen);
      $display("mismatches: %0d", err_cnt);
      if (err_cnt == 0 && want_taken_q.size() == 0) begin
        $display("== PASS ==");
      end else begin
        $display("== FAIL ==");
      end
    end
    $finish;
  end

endmodule

`default_nettype wire
